// ===== hw/rtl/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, codes and helpers shared by the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int SLOT_MAX         = 22;
  localparam int DIGIT_SLOTS_DEF  = 22;
  localparam int DIGIT_W          = 4;
  localparam int STORE_W          = SLOT_MAX * DIGIT_W;
  localparam int VALUE_W          = 64;
  localparam int BITCNT_W         = 7;

  localparam logic [1:0] KIND_DEC = 2'd0;
  localparam logic [1:0] KIND_OCT = 2'd1;
  localparam logic [1:0] KIND_HEX = 2'd2;
  localparam logic [1:0] KIND_LIT = 2'd3;

  localparam logic [1:0] SIZE_16  = 2'd0;
  localparam logic [1:0] SIZE_32  = 2'd1;
  localparam logic [1:0] SIZE_64  = 2'd2;
  // unused size code, handled as sixty-four-bit
  localparam logic [1:0] SIZE_64_ALT = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_A     = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_ALIGN,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_ALIGN,
    OP_SHIFT
  } sreg_op_t;

  typedef struct packed {
    sreg_op_t op;
    logic     bit_in;
  } sreg_ctrl_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         operand_size;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/i2a_digit_sreg.sv =====
// ----------------------------------------------------------------------------
// i2a_digit_sreg
// Digit shift register: binary-to-BCD shift-add-3 conversion one bit per
// cycle, then readout one digit per cycle from the top.
// ----------------------------------------------------------------------------
module i2a_digit_sreg
  import i2a_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic                clk,
  input  sreg_ctrl_t          ctrl,
  input  logic [STORE_W-1:0]  load_data,
  output logic [DIGIT_W-1:0]  top_digit,
  output logic                overflow
);

  // digits above the store depth; all-zero mask when the store is full size
  localparam logic [STORE_W-1:0] HI_MASK =
    ~((STORE_W'(1) << (DIGIT_SLOTS * DIGIT_W)) - STORE_W'(1));
  localparam int ALIGN_SH = (SLOT_MAX - DIGIT_SLOTS) * DIGIT_W;

  logic [STORE_W-1:0] digits;
  logic [STORE_W-1:0] digits_next;
  logic [STORE_W-1:0] adjusted;

  always_comb begin
    logic [DIGIT_W-1:0] d;
    adjusted = '0;
    for (int i = 0; i < SLOT_MAX; i++) begin
      d = digits[i*DIGIT_W +: DIGIT_W];
      if (d inside {[4'd5:4'd15]}) begin
        adjusted[i*DIGIT_W +: DIGIT_W] = d + 4'd3;
      end else begin
        adjusted[i*DIGIT_W +: DIGIT_W] = d;
      end
    end
  end

  always_comb begin
    case (ctrl.op)
      OP_LOAD:   digits_next = load_data;
      OP_DABBLE: digits_next = {adjusted[STORE_W-2:0], ctrl.bit_in};
      OP_ALIGN:  digits_next = digits << ALIGN_SH;
      OP_SHIFT:  digits_next = {digits[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      default:   digits_next = digits;
    endcase
  end

  always_ff @(posedge clk) begin
    digits <= digits_next;
  end

  assign top_digit = digits[STORE_W-1 -: DIGIT_W];
  assign overflow  = |(digits & HI_MASK);

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer as ASCII decimal, octal or hex, one character a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Command in: operand is taken at a clock edge with start high, busy low.
//   Result out: one character per beat, on result for one cycle with strobe
//   high; result.last marks the final character. The receiver cannot stall.
// Timing:
//   Literal kind: one character in the cycle after the command; busy stays
//   low, so a new command may follow at once.
//   Decimal: shift-add-3 over each bit of the 16-, 32- or 64-bit operand
//   (one operand bit per cycle through the digit shift register), an align
//   step, a '-' beat if negative, then readout of the DIGIT_SLOTS digits,
//   one digit per cycle from the top, leading zeros suppressed (no beat).
//   Octal/hex: digits loaded at the command, an align step, then readout.
//   busy is high from the command until the last beat goes out.
// Reset: rst is synchronous, active high; the block returns to idle and no
//   beat is pending.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
  import i2a_pkg::*;
#(
  parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  operand,
  output out_t result,
  output logic strobe
);

  localparam int IDX_W = $clog2(DIGIT_SLOTS);

  state_t               state, state_next;
  logic [VALUE_W-1:0]   work_value, work_value_next;
  logic [BITCNT_W-1:0]  bit_cnt, bit_cnt_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic                 neg, neg_next;
  logic                 seen, seen_next;
  out_t                 result_next;
  logic                 strobe_next;

  sreg_ctrl_t           sreg_ctrl;
  logic [STORE_W-1:0]   load_data;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 overflow;

  logic                 accept;
  logic [VALUE_W-1:0]   ext_value;
  logic [VALUE_W-1:0]   aligned_mag;
  logic [BITCNT_W-1:0]  op_bits;
  logic                 op_neg;
  logic                 digit_nz;
  logic                 emit_digit;

  assign accept   = start && (state == ST_IDLE);
  assign digit_nz = (top_digit != '0);

  // operand prep: mask or sign-extend to 64 bits, take magnitude, left-align
  always_comb begin
    logic [VALUE_W-1:0] mag;
    logic               sx;
    sx = (operand.kind == KIND_DEC);
    case (operand.operand_size)
      SIZE_16: begin
        ext_value = {{48{sx & operand.value[15]}}, operand.value[15:0]};
        op_bits   = BITCNT_W'(16);
      end
      SIZE_32: begin
        ext_value = {{32{sx & operand.value[31]}}, operand.value[31:0]};
        op_bits   = BITCNT_W'(32);
      end
      default: begin
        ext_value = operand.value;
        op_bits   = BITCNT_W'(64);
      end
    endcase
    op_neg = sx & ext_value[VALUE_W-1];
    mag    = op_neg ? (VALUE_W'(0) - ext_value) : ext_value;
    case (operand.operand_size)
      SIZE_16: aligned_mag = mag << 48;
      SIZE_32: aligned_mag = mag << 32;
      default: aligned_mag = mag;
    endcase
  end

  // direct digit layout for octal and hex
  always_comb begin
    logic [VALUE_W+1:0] v66;
    v66       = {2'b00, ext_value};
    load_data = '0;
    if (operand.kind == KIND_OCT) begin
      for (int i = 0; i < SLOT_MAX; i++) begin
        load_data[i*DIGIT_W +: 3] = v66[i*3 +: 3];
      end
    end else if (operand.kind == KIND_HEX) begin
      load_data[VALUE_W-1:0] = ext_value;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operand.kind)
            KIND_DEC: state_next = ST_DABBLE;
            KIND_OCT,
            KIND_HEX: state_next = ST_ALIGN;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DABBLE: if (bit_cnt == BITCNT_W'(1)) state_next = ST_ALIGN;
      ST_ALIGN:  state_next = neg ? ST_SIGN : ST_EMIT;
      ST_SIGN:   state_next = ST_EMIT;
      ST_EMIT:   if (idx == '0) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sreg_ctrl.op     = OP_HOLD;
    sreg_ctrl.bit_in = work_value[VALUE_W-1];
    work_value_next  = work_value;
    bit_cnt_next     = bit_cnt;
    idx_next         = idx;
    neg_next         = neg;
    seen_next        = seen;
    result_next      = result;
    strobe_next      = 1'b0;
    emit_digit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operand.kind)
            KIND_LIT: begin
              result_next.character = operand.value[7:0];
              result_next.last      = 1'b1;
              strobe_next           = 1'b1;
            end
            KIND_DEC: begin
              sreg_ctrl.op    = OP_LOAD;
              work_value_next = aligned_mag;
              bit_cnt_next    = op_bits;
              neg_next        = op_neg;
            end
            default: begin
              sreg_ctrl.op = OP_LOAD;
              neg_next     = 1'b0;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        sreg_ctrl.op    = OP_DABBLE;
        work_value_next = work_value << 1;
        bit_cnt_next    = bit_cnt - BITCNT_W'(1);
      end
      ST_ALIGN: begin
        sreg_ctrl.op = OP_ALIGN;
        seen_next    = overflow;   // dropped high digits force zeros to print
        idx_next     = IDX_W'(DIGIT_SLOTS - 1);
      end
      ST_SIGN: begin
        result_next.character = CHAR_MINUS;
        result_next.last      = 1'b0;
        strobe_next           = 1'b1;
      end
      ST_EMIT: begin
        sreg_ctrl.op          = OP_SHIFT;
        idx_next              = idx - IDX_W'(1);
        seen_next             = seen | digit_nz;
        emit_digit            = seen | digit_nz | (idx == '0);
        result_next.character = digit_char(top_digit);
        result_next.last      = (idx == '0);
        strobe_next           = emit_digit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
    work_value <= work_value_next;
    bit_cnt    <= bit_cnt_next;
    idx        <= idx_next;
    neg        <= neg_next;
    seen       <= seen_next;
    result     <= result_next;
  end

  assign busy = (state != ST_IDLE);

  i2a_digit_sreg #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_digits (
    .clk       (clk),
    .ctrl      (sreg_ctrl),
    .load_data (load_data),
    .top_digit (top_digit),
    .overflow  (overflow)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives integer_to_ascii_formatter with decimal, octal, hex and literal
// commands and checks every character beat against a built-in formatter.
// ----------------------------------------------------------------------------
module tb_top;
  import i2a_pkg::*;

  localparam int SLOTS          = DIGIT_SLOTS_DEF;
  localparam int RANDOM_CMDS    = 307;
  localparam int PHASE1_END     = 130;
  localparam int PHASE2_END     = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;
  localparam int MAX_REPORTS    = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  operand = '0;
  out_t result;
  logic strobe;

  in_t  cmd_backlog[$];
  out_t text_due[$];
  int   cmds_taken = 0;
  int   errors = 0;
  int   quiet_cycles = 0;

  integer_to_ascii_formatter #(
    .DIGIT_SLOTS(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .result(result),
    .strobe(strobe)
  );

  always #6 clk = ~clk;

  // Expected text of one command, most significant character first.
  function automatic void format_text(in_t cmd);
    logic [63:0] num;
    logic [63:0] base;
    logic [3:0]  digits[SLOT_MAX];
    logic [7:0]  ch;
    logic        neg;
    int          ndig;
    neg = 1'b0;
    if (cmd.kind == KIND_LIT) begin
      text_due.push_back(out_t'{character: cmd.value[7:0], last: 1'b1});
      return;
    end
    case (cmd.operand_size)
      SIZE_16: begin
        num = {48'd0, cmd.value[15:0]};
        if (cmd.kind == KIND_DEC && cmd.value[15]) num[63:16] = '1;
      end
      SIZE_32: begin
        num = {32'd0, cmd.value[31:0]};
        if (cmd.kind == KIND_DEC && cmd.value[31]) num[63:32] = '1;
      end
      default: num = cmd.value;
    endcase
    if (cmd.kind == KIND_DEC) begin
      base = 64'd10;
      if (num[63]) begin
        neg = 1'b1;
        num = 64'd0 - num;
      end
    end else if (cmd.kind == KIND_OCT) begin
      base = 64'd8;
    end else begin
      base = 64'd16;
    end
    ndig = 0;
    do begin
      digits[ndig] = 4'(num % base);
      ndig++;
      num = num / base;
    end while (num != 0 && ndig < SLOTS);
    if (neg) text_due.push_back(out_t'{character: CHAR_MINUS, last: 1'b0});
    for (int i = ndig - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) ch = CHAR_ZERO + 8'(digits[i]);
      else ch = CHAR_A + 8'(digits[i] - 4'd10);
      text_due.push_back(out_t'{character: ch, last: (i == 0)});
    end
  endfunction

  task automatic queue_cmd(input logic [1:0] kind, input logic [1:0] size,
                           input logic [63:0] value);
    cmd_backlog.push_back(in_t'{kind: kind, operand_size: size, value: value});
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: v = 64'($urandom_range(0, 20));
      3: v = ~64'd0 >> $urandom_range(0, 63);
      4: v = 64'd1 << $urandom_range(0, 63);
      // random values with the sign bit of one size (bit 15, 31 or 63) flipped
      default: v = {$urandom, $urandom} ^ (64'd1 << (16 << $urandom_range(0, 2)) - 1);
    endcase
    return v;
  endfunction

  // Driver: a beat stays on the bus until busy is low at an edge.
  always @(posedge clk) begin : drive_cmd
    int pct;
    if (rst) begin
      start <= 1'b0;
      operand <= '0;
    end else begin
      if (start && !busy) begin
        format_text(operand);
        void'(cmd_backlog.pop_front());
        cmds_taken <= cmds_taken + 1;
      end
      if (!(start && busy)) begin
        pct = (cmds_taken < PHASE1_END) ? 20 : (cmds_taken < PHASE2_END) ? 70 : 0;
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= pct) begin
          start <= 1'b1;
          operand <= cmd_backlog[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed beat must match the oldest expected character.
  always @(posedge clk) begin : check_beat
    out_t want;
    if (!rst && strobe) begin
      if (text_due.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_REPORTS)
          $display("unexpected beat: character %h last %b", result.character, result.last);
      end else begin
        want = text_due.pop_front();
        if (result.character !== want.character || result.last !== want.last) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("mismatch: expected character %h last %b, got character %h last %b",
                     want.character, want.last, result.character, result.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    // signed decimal edges, including the most negative value of each size
    queue_cmd(KIND_DEC, SIZE_16, 64'd0);
    queue_cmd(KIND_DEC, SIZE_16, 64'hffff_ffff_ffff_8000);
    queue_cmd(KIND_DEC, SIZE_16, 64'h0000_0000_0000_7fff);
    queue_cmd(KIND_DEC, SIZE_16, 64'h1234_5678_9abc_ffff);
    queue_cmd(KIND_DEC, SIZE_32, 64'h0000_0000_8000_0000);
    queue_cmd(KIND_DEC, SIZE_32, 64'hffff_ffff_7fff_ffff);
    queue_cmd(KIND_DEC, SIZE_64, 64'h8000_0000_0000_0000);
    queue_cmd(KIND_DEC, SIZE_64, 64'h7fff_ffff_ffff_ffff);
    queue_cmd(KIND_DEC, SIZE_64, 64'hffff_ffff_ffff_ffff);
    queue_cmd(KIND_DEC, SIZE_64, 64'd0);
    // size code three acts as sixty-four-bit
    queue_cmd(KIND_DEC, SIZE_64_ALT, 64'hffff_ffff_ffff_fff6);
    queue_cmd(KIND_OCT, SIZE_64_ALT, 64'h8000_0000_0000_0000);
    // octal fills every digit slot at 64 bits
    queue_cmd(KIND_OCT, SIZE_64, 64'hffff_ffff_ffff_ffff);
    queue_cmd(KIND_OCT, SIZE_16, 64'hffff_ffff_ffff_0000);
    queue_cmd(KIND_OCT, SIZE_32, 64'h0000_0000_ffff_ffff);
    queue_cmd(KIND_HEX, SIZE_64, 64'hffff_ffff_ffff_ffff);
    queue_cmd(KIND_HEX, SIZE_16, 64'hdead_beef_0000_abcd);
    queue_cmd(KIND_HEX, SIZE_32, 64'h0000_0000_0000_0000);
    queue_cmd(KIND_HEX, SIZE_64_ALT, 64'h0123_4567_89ab_cdef);
    queue_cmd(KIND_LIT, SIZE_16, 64'd0);
    queue_cmd(KIND_LIT, SIZE_64_ALT, 64'hffff_ffff_ffff_ffff);
    queue_cmd(KIND_LIT, SIZE_32, 64'h0000_0000_0000_0041);
    queue_cmd(KIND_LIT, SIZE_64, 64'h0000_0000_0000_002d);
    for (int n = 0; n < RANDOM_CMDS; n++)
      queue_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_value());

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (cmd_backlog.size() != 0 || text_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
